[rtl/assert_macros.svh]
// assertion macros used by dense_trajectory_resampler
// expects i_clk and i_rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent checked in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/dtr_pkg.sv]
// types and constants of the dense trajectory resampler
// used by dtr_ctrl, dtr_datapath and dense_trajectory_resampler
`default_nettype none

package dtr_pkg;

    localparam int PI_Q     = 25736;
    localparam int TWO_PI_Q = 51472;
    localparam logic [30:0] ARC_MAX = 31'h7FFF_FFFF;

    localparam int LANES = 7;
    localparam int LW    = 33;
    localparam int DCW   = $clog2(LW + 1);

    localparam int L_X  = 0;
    localparam int L_Y  = 1;
    localparam int L_H  = 2;
    localparam int L_PL = 3;
    localparam int L_SP = 4;
    localparam int L_AC = 5;
    localparam int L_T  = 6;

    localparam logic REG_TIME_STEP = 1'b0;
    localparam logic [9:0] TIME_STEP_RESET = 10'd100;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic        [30:0] path_length;
        logic signed [15:0] speed;
        logic signed [15:0] accel;
        logic        [19:0] time_ms;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [15:0] out_heading;
        logic        [30:0] arc_length;
        logic        [30:0] ref_length;
        logic signed [15:0] out_speed;
        logic signed [15:0] out_accel;
        logic        [19:0] out_time_ms;
        logic               end_of_run;
        logic               clamped;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COUNT,
        ST_DIV,
        ST_SQA,
        ST_SQB,
        ST_RINIT,
        ST_ROOT,
        ST_EINIT,
        ST_EMIT,
        ST_FINAL,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic count_init;
        logic count_step;
        logic div_init;
        logic div_step;
        logic sq_a;
        logic sq_b;
        logic root_init;
        logic root_step;
        logic emit_init;
        logic emit_step;
        logic emit_final;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic seg_ok;
        logic last;
        logic count_done;
        logic div_done;
        logic root_done;
        logic emit_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

[rtl/dtr_ctrl.sv]
// controller state machine of the resampler
// depends on dtr_pkg; drives dtr_datapath through command and status structs
`default_nettype none

module dtr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire dtr_pkg::t_stat i_stat,
    output dtr_pkg::t_cmd      o_cmd
);

    dtr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dtr_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = dtr_pkg::ST_CHECK;
            end
            dtr_pkg::ST_CHECK: begin
                priority if (i_stat.seg_ok) n_state = dtr_pkg::ST_COUNT;
                else if (i_stat.last)       n_state = dtr_pkg::ST_FINAL;
                else                        n_state = dtr_pkg::ST_COMMIT;
            end
            dtr_pkg::ST_COUNT: begin
                if (i_stat.count_done) n_state = dtr_pkg::ST_DIV;
            end
            dtr_pkg::ST_DIV: begin
                if (i_stat.div_done) n_state = dtr_pkg::ST_SQA;
            end
            dtr_pkg::ST_SQA:   n_state = dtr_pkg::ST_SQB;
            dtr_pkg::ST_SQB:   n_state = dtr_pkg::ST_RINIT;
            dtr_pkg::ST_RINIT: n_state = dtr_pkg::ST_ROOT;
            dtr_pkg::ST_ROOT: begin
                if (i_stat.root_done) n_state = dtr_pkg::ST_EINIT;
            end
            dtr_pkg::ST_EINIT: n_state = dtr_pkg::ST_EMIT;
            dtr_pkg::ST_EMIT: begin
                if (i_stat.out_free && i_stat.emit_last) begin
                    n_state = i_stat.last ? dtr_pkg::ST_FINAL : dtr_pkg::ST_COMMIT;
                end
            end
            dtr_pkg::ST_FINAL: begin
                if (i_stat.out_free) n_state = dtr_pkg::ST_IDLE;
            end
            dtr_pkg::ST_COMMIT: n_state = dtr_pkg::ST_IDLE;
            default: n_state = dtr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            dtr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            dtr_pkg::ST_CHECK: begin
                o_cmd.count_init = i_stat.seg_ok;
            end
            dtr_pkg::ST_COUNT: begin
                o_cmd.div_init   = i_stat.count_done;
                o_cmd.count_step = !i_stat.count_done;
            end
            dtr_pkg::ST_DIV: begin
                o_cmd.div_step = !i_stat.div_done;
            end
            dtr_pkg::ST_SQA:   o_cmd.sq_a = 1'b1;
            dtr_pkg::ST_SQB:   o_cmd.sq_b = 1'b1;
            dtr_pkg::ST_RINIT: o_cmd.root_init = 1'b1;
            dtr_pkg::ST_ROOT: begin
                o_cmd.root_step = !i_stat.root_done;
            end
            dtr_pkg::ST_EINIT: o_cmd.emit_init = 1'b1;
            dtr_pkg::ST_EMIT: begin
                o_cmd.emit_step = i_stat.out_free;
            end
            dtr_pkg::ST_FINAL: begin
                o_cmd.emit_final = i_stat.out_free;
            end
            dtr_pkg::ST_COMMIT: o_cmd.commit = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/dtr_datapath.sv]
// datapath of the resampler: segment count, lane dividers, root, interpolators
// depends on dtr_pkg; commanded by dtr_ctrl
`default_nettype none

module dtr_datapath #(
    parameter int MAX_SUBSTEPS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire dtr_pkg::t_cmd     i_cmd,
    output dtr_pkg::t_stat         o_stat,
    input  wire dtr_pkg::t_in_item i_in_item,
    input  wire logic [9:0]        i_time_step,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output dtr_pkg::t_out_item     o_out_item
);

    localparam int NW = $clog2(MAX_SUBSTEPS + 1);
    localparam logic [NW-1:0] MAX_N = NW'(MAX_SUBSTEPS);

    typedef logic [dtr_pkg::LW-1:0] t_lane;
    typedef logic [NW-1:0]          t_rem;

    function automatic logic signed [15:0] wrap_h(input logic signed [17:0] h);
        logic signed [18:0] v;
        begin
            v = 19'(h) + 19'(dtr_pkg::PI_Q);
            if (v < 19'sd0) begin
                v = v + 19'(dtr_pkg::TWO_PI_Q);
            end else if (v >= 19'(dtr_pkg::TWO_PI_Q)) begin
                v = v - 19'(dtr_pkg::TWO_PI_Q);
            end
            v = v - 19'(dtr_pkg::PI_Q);
            return v[15:0];
        end
    endfunction

    dtr_pkg::t_in_item r_cur;
    logic               r_have_prev;
    logic signed [31:0] r_prev_x, r_prev_y;
    logic signed [15:0] r_prev_h, r_prev_sp, r_prev_ac;
    logic        [30:0] r_prev_pl;
    logic        [19:0] r_prev_t;
    logic        [30:0] r_acc;

    logic [NW-1:0] r_n;
    logic [20:0]   r_kacc;
    logic          r_clamped;

    t_lane          r_dv  [dtr_pkg::LANES];
    t_rem           r_rem [dtr_pkg::LANES];
    logic           r_neg [dtr_pkg::LANES];
    logic [dtr_pkg::DCW-1:0] r_dcnt;

    logic [61:0] r_sq;
    logic [62:0] r_s2;
    logic        r_sat;
    logic [63:0] r_v, r_root;
    logic [5:0]  r_rcnt;
    logic [30:0] r_ds;

    t_lane          r_q [dtr_pkg::LANES];
    t_rem           r_r [dtr_pkg::LANES];
    logic [NW-1:0]  r_j;

    dtr_pkg::t_out_item r_out;
    logic               r_out_valid;

    logic [9:0]  step;
    logic [20:0] dt;
    logic        kmore;
    logic signed [17:0] hdiff;
    logic signed [33:0] d [dtr_pkg::LANES];
    t_lane       mag [dtr_pkg::LANES];
    t_lane       dv_nx [dtr_pkg::LANES];
    t_rem        rem_nx [dtr_pkg::LANES];
    t_lane       mag1 [dtr_pkg::LANES];
    t_lane       q_nx [dtr_pkg::LANES];
    t_rem        r_nx [dtr_pkg::LANES];
    logic signed [33:0] s [dtr_pkg::LANES];
    logic [NW-1:0] half;
    logic [30:0] sq_op;
    logic [61:0] sq;
    logic [63:0] bitv, trial;
    logic [63:0] rnd;
    logic [31:0] acc_sum;
    logic        out_free;
    dtr_pkg::t_out_item seg_pt;

    assign step  = (i_time_step == 10'd0) ? 10'd1 : i_time_step;
    assign dt    = {1'b0, r_cur.time_ms} - {1'b0, r_prev_t};
    assign kmore = (r_kacc < dt);
    assign half  = r_n >> 1;
    assign hdiff = {{2{r_cur.heading[15]}}, r_cur.heading} - {{2{r_prev_h[15]}}, r_prev_h};

    always_comb begin
        d[dtr_pkg::L_X]  = {{2{r_cur.pos_x[31]}}, r_cur.pos_x} - {{2{r_prev_x[31]}}, r_prev_x};
        d[dtr_pkg::L_Y]  = {{2{r_cur.pos_y[31]}}, r_cur.pos_y} - {{2{r_prev_y[31]}}, r_prev_y};
        d[dtr_pkg::L_H]  = 34'(wrap_h(hdiff));
        d[dtr_pkg::L_PL] = {3'b0, r_cur.path_length} - {3'b0, r_prev_pl};
        d[dtr_pkg::L_SP] = {{18{r_cur.speed[15]}}, r_cur.speed}
                         - {{18{r_prev_sp[15]}}, r_prev_sp};
        d[dtr_pkg::L_AC] = {{18{r_cur.accel[15]}}, r_cur.accel}
                         - {{18{r_prev_ac[15]}}, r_prev_ac};
        d[dtr_pkg::L_T]  = {14'b0, r_cur.time_ms} - {14'b0, r_prev_t};
        for (int l = 0; l < dtr_pkg::LANES; l++) begin
            mag[l] = d[l][33] ? dtr_pkg::LW'(-d[l]) : d[l][dtr_pkg::LW-1:0];
        end
    end

    // restoring division, one quotient bit per lane per cycle
    always_comb begin
        for (int l = 0; l < dtr_pkg::LANES; l++) begin
            logic [NW:0] t;
            logic        ge;
            t  = {r_rem[l], r_dv[l][dtr_pkg::LW-1]};
            ge = (t >= {1'b0, r_n});
            rem_nx[l] = ge ? NW'(t - {1'b0, r_n}) : t[NW-1:0];
            dv_nx[l]  = {r_dv[l][dtr_pkg::LW-2:0], ge};
            mag1[l]   = r_dv[l] + dtr_pkg::LW'(({1'b0, r_rem[l]} + {1'b0, half}) >= {1'b0, r_n});
        end
    end

    // incremental quotient and remainder of j*|d|/n with half-up offset
    always_comb begin
        for (int l = 0; l < dtr_pkg::LANES; l++) begin
            logic [NW:0] rs;
            rs = {1'b0, r_r[l]} + {1'b0, r_rem[l]};
            if (rs >= {1'b0, r_n}) begin
                r_nx[l] = NW'(rs - {1'b0, r_n});
                q_nx[l] = r_q[l] + r_dv[l] + dtr_pkg::LW'(1);
            end else begin
                r_nx[l] = rs[NW-1:0];
                q_nx[l] = r_q[l] + r_dv[l];
            end
            s[l] = r_neg[l] ? -{1'b0, r_q[l]} : {1'b0, r_q[l]};
        end
    end

    assign sq_op = r_sq == '0 && i_cmd.sq_a ? mag1[dtr_pkg::L_X][30:0]
                 : (i_cmd.sq_a ? mag1[dtr_pkg::L_X][30:0] : mag1[dtr_pkg::L_Y][30:0]);
    assign sq    = sq_op * sq_op;

    assign bitv  = 64'h4000_0000_0000_0000 >> {r_rcnt[4:0], 1'b0};
    assign trial = r_root + bitv;
    assign rnd   = (r_v > r_root) ? r_root + 64'd1 : r_root;

    assign acc_sum  = {1'b0, r_acc} + {1'b0, r_ds};
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        seg_pt.out_x       = r_prev_x + s[dtr_pkg::L_X][31:0];
        seg_pt.out_y       = r_prev_y + s[dtr_pkg::L_Y][31:0];
        seg_pt.out_heading = wrap_h({{2{r_prev_h[15]}}, r_prev_h} + s[dtr_pkg::L_H][17:0]);
        seg_pt.arc_length  = r_acc;
        seg_pt.ref_length  = r_prev_pl + s[dtr_pkg::L_PL][30:0];
        seg_pt.out_speed   = r_prev_sp + s[dtr_pkg::L_SP][15:0];
        seg_pt.out_accel   = r_prev_ac + s[dtr_pkg::L_AC][15:0];
        seg_pt.out_time_ms = r_prev_t + s[dtr_pkg::L_T][19:0];
        seg_pt.end_of_run  = (r_j == r_n - NW'(1)) && !r_cur.last;
        seg_pt.clamped     = r_clamped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load && !r_have_prev) r_acc <= '0;
            if (i_cmd.commit) r_have_prev <= 1'b1;
            if (i_cmd.emit_step) begin
                r_acc <= acc_sum[31] ? dtr_pkg::ARC_MAX : acc_sum[30:0];
            end
            if (i_cmd.emit_final) begin
                r_have_prev <= 1'b0;
                r_acc       <= '0;
            end
            if (i_cmd.emit_step || i_cmd.emit_final) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_cur <= i_in_item;
        if (i_cmd.commit) begin
            r_prev_x  <= r_cur.pos_x;
            r_prev_y  <= r_cur.pos_y;
            r_prev_h  <= r_cur.heading;
            r_prev_pl <= r_cur.path_length;
            r_prev_sp <= r_cur.speed;
            r_prev_ac <= r_cur.accel;
            r_prev_t  <= r_cur.time_ms;
        end
        if (i_cmd.count_init) begin
            r_n    <= NW'(1);
            r_kacc <= 21'(step);
        end else if (i_cmd.count_step) begin
            r_n    <= r_n + NW'(1);
            r_kacc <= r_kacc + 21'(step);
        end
        if (i_cmd.div_init) begin
            r_clamped <= kmore;
            r_dcnt    <= '0;
            for (int l = 0; l < dtr_pkg::LANES; l++) begin
                r_dv[l]  <= mag[l];
                r_rem[l] <= '0;
                r_neg[l] <= d[l][33];
            end
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + dtr_pkg::DCW'(1);
            for (int l = 0; l < dtr_pkg::LANES; l++) begin
                r_dv[l]  <= dv_nx[l];
                r_rem[l] <= rem_nx[l];
            end
        end
        if (i_cmd.sq_a) r_sq <= sq;
        if (i_cmd.sq_b) begin
            r_s2  <= {1'b0, r_sq} + {1'b0, sq};
            r_sat <= (mag1[dtr_pkg::L_X] >= dtr_pkg::LW'(33'h0_8000_0000))
                  || (mag1[dtr_pkg::L_Y] >= dtr_pkg::LW'(33'h0_8000_0000));
        end
        if (i_cmd.root_init) begin
            r_v    <= {1'b0, r_s2};
            r_root <= '0;
            r_rcnt <= '0;
        end else if (i_cmd.root_step) begin
            r_rcnt <= r_rcnt + 6'd1;
            if (r_v >= trial) begin
                r_v    <= r_v - trial;
                r_root <= (r_root >> 1) + bitv;
            end else begin
                r_root <= r_root >> 1;
            end
        end
        if (i_cmd.emit_init) begin
            r_ds <= (r_sat || rnd > {33'b0, dtr_pkg::ARC_MAX}) ? dtr_pkg::ARC_MAX : rnd[30:0];
            r_j  <= '0;
            for (int l = 0; l < dtr_pkg::LANES; l++) begin
                r_q[l] <= '0;
                r_r[l] <= half;
            end
        end else if (i_cmd.emit_step) begin
            r_j <= r_j + NW'(1);
            for (int l = 0; l < dtr_pkg::LANES; l++) begin
                r_q[l] <= q_nx[l];
                r_r[l] <= r_nx[l];
            end
        end
        if (i_cmd.emit_step) begin
            r_out <= seg_pt;
        end else if (i_cmd.emit_final) begin
            r_out.out_x       <= r_cur.pos_x;
            r_out.out_y       <= r_cur.pos_y;
            r_out.out_heading <= r_cur.heading;
            r_out.arc_length  <= r_acc;
            r_out.ref_length  <= r_cur.path_length;
            r_out.out_speed   <= r_cur.speed;
            r_out.out_accel   <= r_cur.accel;
            r_out.out_time_ms <= r_cur.time_ms;
            r_out.end_of_run  <= 1'b1;
            r_out.clamped     <= 1'b0;
        end
    end

    always_comb begin
        o_stat.seg_ok     = r_have_prev && !dt[20] && (dt != 21'd0);
        o_stat.last       = r_cur.last;
        o_stat.count_done = !(kmore && (r_n < MAX_N));
        o_stat.div_done   = (r_dcnt == dtr_pkg::DCW'(dtr_pkg::LW));
        o_stat.root_done  = (r_rcnt == 6'd32);
        o_stat.emit_last  = (r_j == r_n - NW'(1));
        o_stat.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

[rtl/dense_trajectory_resampler.sv]
// Resamples a trajectory point stream to a fixed time spacing. One item is worked on at a
// time: after acceptance the block checks the segment, finds the point count n, runs the
// bit-serial lane dividers, forms the squares and the root setup, runs the bit-pair square
// root of the step length, starts the interpolators, emits one point per cycle while the
// output is taken and closes the item. A first point or a segment with no forward time goes
// from the check straight to closing the item.
`default_nettype none
`include "assert_macros.svh"

module dense_trajectory_resampler #(
    parameter int MAX_SUBSTEPS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire dtr_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output dtr_pkg::t_out_item      o_out_item,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [9:0]     r_time_step;
    logic           cfg_wr;
    dtr_pkg::t_cmd  cmd;
    dtr_pkg::t_stat stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == dtr_pkg::REG_TIME_STEP);
    assign prdata = (paddr == 3'd0) ? {22'b0, r_time_step} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= dtr_pkg::TIME_STEP_RESET;
        end else if (cfg_wr) begin
            r_time_step <= pwdata[9:0];
        end
    end

    dtr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dtr_datapath #(
        .MAX_SUBSTEPS (MAX_SUBSTEPS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_item   (i_in_item),
        .i_time_step (r_time_step),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    `ASSERT_NEXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready, "item taken while busy")
    `ASSERT_NEXT(a_cfg_write, cfg_wr, r_time_step == $past(pwdata[9:0]), "time step not written")
    `ASSERT_SAME(a_ready_idle, o_in_ready, !o_out_valid || o_out_item.end_of_run, "early ready")

endmodule

`default_nettype wire

[dv/testbench.sv]
// self-checking testbench of dense_trajectory_resampler
// predicts each resampled point from the accepted items; needs dtr_pkg and the rtl
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_STEPS = 32;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    dtr_pkg::t_in_item  i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    dtr_pkg::t_out_item o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    dense_trajectory_resampler #(.MAX_SUBSTEPS(MAX_STEPS)) u_top (.*);

    dtr_pkg::t_in_item  point_q[$];
    dtr_pkg::t_out_item point_exp_q[$];
    int        idle_pct = 34;
    int        errors = 0;

    // predictor state
    bit [9:0] step_ms = dtr_pkg::TIME_STEP_RESET;
    bit       have_prev;
    longint   p_x, p_y, p_h, p_pl, p_sp, p_ac, p_t, arc_acc;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint div_rnd(longint num, longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint wrap_h(longint h);
        longint r;
        r = (h + dtr_pkg::PI_Q) % dtr_pkg::TWO_PI_Q;
        if (r < 0) r += dtr_pkg::TWO_PI_Q;
        return r - dtr_pkg::PI_Q;
    endfunction

    function automatic longint unsigned sqrt_rnd(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return (v > r) ? r + 1 : r;
    endfunction

    function automatic dtr_pkg::t_out_item make_point(longint x, longint y, longint h,
                                                      longint arc, longint rl, longint sp,
                                                      longint ac, longint t, bit clp);
        dtr_pkg::t_out_item o;
        o.out_x = x[31:0];
        o.out_y = y[31:0];
        o.out_heading = h[15:0];
        o.arc_length = arc[30:0];
        o.ref_length = rl[30:0];
        o.out_speed = sp[15:0];
        o.out_accel = ac[15:0];
        o.out_time_ms = t[19:0];
        o.end_of_run = 1'b0;
        o.clamped = clp;
        return o;
    endfunction

    task automatic predict_points(dtr_pkg::t_in_item it);
        longint x, y, h, pl, sp, ac, t, dt, stp, n, dx, dy, dh, sx1, sy1, ds;
        longint unsigned r;
        bit clp;
        dtr_pkg::t_out_item res[$];
        x = longint'(it.pos_x);
        y = longint'(it.pos_y);
        h = longint'(it.heading);
        pl = longint'(it.path_length);
        sp = longint'(it.speed);
        ac = longint'(it.accel);
        t = longint'(it.time_ms);
        if (have_prev) begin
            dt = t - p_t;
            if (dt > 0) begin
                stp = (step_ms == 0) ? 1 : longint'(step_ms);
                n = (dt + stp - 1) / stp;
                clp = 1'b0;
                if (n > MAX_STEPS) begin
                    n = MAX_STEPS;
                    clp = 1'b1;
                end
                dx = x - p_x;
                dy = y - p_y;
                dh = wrap_h(h - p_h);
                sx1 = div_rnd(dx, n);
                sy1 = div_rnd(dy, n);
                if (sx1 <= -64'sd2147483648 || sx1 > 64'sd2147483647 ||
                    sy1 <= -64'sd2147483648 || sy1 > 64'sd2147483647) begin
                    ds = 64'sd2147483647;
                end else begin
                    r = sqrt_rnd(longint'(sx1 * sx1) + longint'(sy1 * sy1));
                    ds = (r > 64'd2147483647) ? 64'sd2147483647 : longint'(r);
                end
                for (longint j = 0; j < n; j++) begin
                    res.push_back(make_point(p_x + div_rnd(j * dx, n), p_y + div_rnd(j * dy, n),
                        wrap_h(p_h + div_rnd(j * dh, n)), arc_acc,
                        p_pl + div_rnd(j * (pl - p_pl), n), p_sp + div_rnd(j * (sp - p_sp), n),
                        p_ac + div_rnd(j * (ac - p_ac), n), p_t + div_rnd(j * dt, n), clp));
                    arc_acc += ds;
                    if (arc_acc > 64'sd2147483647) arc_acc = 64'sd2147483647;
                end
            end
        end else begin
            arc_acc = 0;
        end
        if (it.last) begin
            res.push_back(make_point(x, y, h, arc_acc, pl, sp, ac, t, 1'b0));
            have_prev = 1'b0;
            arc_acc = 0;
        end else begin
            have_prev = 1'b1;
            p_x = x; p_y = y; p_h = h; p_pl = pl; p_sp = sp; p_ac = ac; p_t = t;
        end
        if (res.size() > 0) res[res.size() - 1].end_of_run = 1'b1;
        foreach (res[k]) point_exp_q.push_back(res[k]);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) predict_points(i_in_item);
            if (!i_in_valid || o_in_ready) begin
                if (point_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_item <= point_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
            errors++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        dtr_pkg::t_out_item e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= idle_pct);
            if (o_out_valid && i_out_ready) begin
                if (point_exp_q.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual %h", $realtime,
                             o_out_item);
                    errors++;
                end else begin
                    e = point_exp_q.pop_front();
                    check_field("out_x", e.out_x, o_out_item.out_x);
                    check_field("out_y", e.out_y, o_out_item.out_y);
                    check_field("out_heading", e.out_heading, o_out_item.out_heading);
                    check_field("arc_length", e.arc_length, o_out_item.arc_length);
                    check_field("ref_length", e.ref_length, o_out_item.ref_length);
                    check_field("out_speed", e.out_speed, o_out_item.out_speed);
                    check_field("out_accel", e.out_accel, o_out_item.out_accel);
                    check_field("out_time_ms", e.out_time_ms, o_out_item.out_time_ms);
                    check_field("end_of_run", e.end_of_run, o_out_item.end_of_run);
                    check_field("clamped", e.clamped, o_out_item.clamped);
                end
            end
        end
    end

    task automatic write_step(bit [9:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(dtr_pkg::REG_TIME_STEP) * 3'd4;
        pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        step_ms = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (point_q.size() > 0 || i_in_valid || point_exp_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic dtr_pkg::t_in_item mk_in(longint x, longint y, longint h, longint pl,
                                                longint sp, longint ac, longint t, bit last);
        dtr_pkg::t_in_item p;
        p.pos_x = x[31:0];
        p.pos_y = y[31:0];
        p.heading = h[15:0];
        p.path_length = pl[30:0];
        p.speed = sp[15:0];
        p.accel = ac[15:0];
        p.time_ms = t[19:0];
        p.last = last;
        return p;
    endfunction

    function automatic dtr_pkg::t_in_item rand_in();
        logic [191:0] raw;
        dtr_pkg::t_in_item p;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        p = raw[$bits(dtr_pkg::t_in_item)-1:0];
        return p;
    endfunction

    // well-formed trajectory with random content, or noise
    task automatic push_traj();
        int len;
        longint x, y, h, pl, t, stp;
        dtr_pkg::t_in_item p;
        len = $urandom_range(6, 1);
        stp = (step_ms == 0) ? 1 : step_ms;
        if ($urandom_range(9) < 2) begin
            repeat (len) point_q.push_back(rand_in());
            return;
        end
        x = $signed($urandom);
        y = $signed($urandom);
        h = $signed(16'($urandom));
        pl = $urandom_range(32'h7FFF_FFFF);
        t = $urandom_range(20'hFFFFF);
        for (int k = 0; k < len; k++) begin
            p = rand_in();
            if ($urandom_range(3) != 0) begin
                x += $signed(18'($urandom));
                y += $signed(18'($urandom));
                h += $signed(14'($urandom));
                pl += $urandom_range(4000);
                p.pos_x = x[31:0];
                p.pos_y = y[31:0];
                p.heading = h[15:0];
                p.path_length = pl[30:0];
            end
            if ($urandom_range(9) == 0) t -= $urandom_range(32'(2 * stp));
            else t += $urandom_range(32'(40 * stp), 1);
            p.time_ms = t[19:0];
            p.last = (k == len - 1);
            point_q.push_back(p);
        end
    endtask

    initial begin
        bit [9:0] steps[5];
        steps = '{10'd1, 10'd1000, 10'd0, 10'd1023, 10'd37};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-point trajectory, extremes, heading wrap, dt zero and negative, clamping
        idle_pct = 34;
        point_q.push_back(mk_in(-2147483648, 2147483647, 25735, 0, -32768, 32767, 0, 1));
        point_q.push_back(mk_in(2147483647, -2147483648, -25736, 31'h7FFF_FFFF,
                                32767, -32768, 20'hFFFFF, 1));
        point_q.push_back(mk_in(0, 0, 25000, 100, 256, 0, 1000, 0));
        point_q.push_back(mk_in(5000, -3000, -25000, 900, 512, -100, 1450, 0));
        point_q.push_back(mk_in(6000, -3000, 0, 950, 512, -100, 1450, 0));
        point_q.push_back(mk_in(7000, 0, 0, 950, 0, 0, 1300, 0));
        point_q.push_back(mk_in(9000, 4000, 3000, 1200, 100, 50, 9999, 0));
        point_q.push_back(mk_in(-2147483648, 2147483647, -32768, 31'h7FFF_FFFF,
                                -32768, 32767, 10099, 0));
        point_q.push_back(mk_in(2147483647, -2147483648, 32767, 0, 32767, -32768,
                                10100, 0));
        point_q.push_back(mk_in(0, 0, 0, 5, 0, 0, 20'hFFFFF, 1));
        point_q.push_back(mk_in(10, 10, 10, 10, 10, 10, 500, 0));
        point_q.push_back(mk_in(10, 10, 10, 10, 10, 10, 400, 1));
        point_q.push_back(mk_in(0, 0, 0, 0, 0, 0, 0, 0));
        point_q.push_back(mk_in(-1, 1, 1, 1, 1, 1, 0, 1));
        drain();

        // ten random trajectories per batch, each batch drained until every point is back
        for (int k = 0; k < 10; k++) push_traj();
        drain();
        for (int k = 0; k < 10; k++) push_traj();
        drain();

        foreach (steps[s]) begin
            write_step(steps[s]);
            idle_pct = (s == 1) ? 0 : 34;
            for (int k = 0; k < 12; k++) push_traj();
            drain();
        end
        write_step(dtr_pkg::TIME_STEP_RESET);
        for (int k = 0; k < 8; k++) push_traj();
        drain();

        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/dtr_pkg.sv
rtl/dtr_ctrl.sv
rtl/dtr_datapath.sv
rtl/dense_trajectory_resampler.sv
dv/testbench.sv
